/* hdl/dct_pkg.sv */
// Shared types, codes and the index decode function for the dual compare timer.
`default_nettype none

package dct_pkg;

  localparam int WORD_WIDTH       = 32;
  localparam int INDEX_WIDTH      = 3;
  localparam int CHAN_WIDTH       = 3;
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int DATA_WIDTH_DEF   = 32;

  // Control word bit positions.
  localparam int TRIG_POS  = 0;
  localparam int IRQEN_POS = 1;
  localparam int AR_POS    = 2;
  localparam int EN_POS    = 3;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    KIND_CTL = 2'd0,
    KIND_CMP = 2'd1,
    KIND_CNT = 2'd2
  } kind_t;

  typedef struct packed {
    func_t                  func;
    logic [INDEX_WIDTH-1:0] reg_index;
    logic [WORD_WIDTH-1:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] read_data;
    logic                  irq_zero;
    logic                  irq_one;
    logic                  bad_access;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_WIDTH-1:0] chan;
    kind_t                 kind;
  } reg_sel_t;

  // Per-channel command for one processing step.
  typedef struct packed {
    logic tick;
    logic wr_ctl;
    logic wr_cmp;
    logic wr_cnt;
  } chan_cmd_t;

  // Splits a word register index into channel and register kind (three per channel).
  function automatic reg_sel_t decode_index(input logic [INDEX_WIDTH-1:0] idx);
    reg_sel_t sel;
    unique case (idx)
      3'd0: sel = '{chan: 3'd0, kind: KIND_CTL};
      3'd1: sel = '{chan: 3'd0, kind: KIND_CMP};
      3'd2: sel = '{chan: 3'd0, kind: KIND_CNT};
      3'd3: sel = '{chan: 3'd1, kind: KIND_CTL};
      3'd4: sel = '{chan: 3'd1, kind: KIND_CMP};
      3'd5: sel = '{chan: 3'd1, kind: KIND_CNT};
      3'd6: sel = '{chan: 3'd2, kind: KIND_CTL};
      default: sel = '{chan: 3'd2, kind: KIND_CMP};
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

/* hdl/dct_channel.sv */
// One timer channel: control, compare and counter words plus the down-counter.
`default_nettype none

module dct_channel #(
  parameter int DATA_WIDTH = dct_pkg::DATA_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  dct_pkg::chan_cmd_t    cmd,
  input  wire  [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] ctl_word,
  output logic [DATA_WIDTH-1:0] cmp_word,
  output logic [DATA_WIDTH-1:0] cnt_word,
  output logic                  irq_nxt
);

  logic [DATA_WIDTH-1:0] ctl_r, ctl_nxt;
  logic [DATA_WIDTH-1:0] cmp_r, cmp_nxt;
  logic [DATA_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] dcount_r, dcount_nxt;
  logic                  run_r, run_nxt;

  always_comb begin
    ctl_nxt    = ctl_r;
    cmp_nxt    = cmp_r;
    cnt_nxt    = cnt_r;
    dcount_nxt = dcount_r;
    run_nxt    = run_r;
    if (cmd.tick) begin
      if (run_r) begin
        if (dcount_r > DATA_WIDTH'(1)) begin
          dcount_nxt = dcount_r - DATA_WIDTH'(1);
        end else begin
          // Hit: latch the trigger, then reload or stop.
          ctl_nxt[dct_pkg::TRIG_POS] = 1'b1;
          if (ctl_r[dct_pkg::AR_POS]) begin
            dcount_nxt = cmp_r;
          end else begin
            dcount_nxt = '0;
            run_nxt    = 1'b0;
          end
        end
      end
    end else if (cmd.wr_ctl) begin
      ctl_nxt                    = wr_data;
      ctl_nxt[dct_pkg::TRIG_POS] = 1'b0;
      run_nxt                    = wr_data[dct_pkg::EN_POS];
    end else if (cmd.wr_cmp) begin
      cmp_nxt    = wr_data;
      dcount_nxt = wr_data;
    end else if (cmd.wr_cnt) begin
      cnt_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r    <= '0;
      cmp_r    <= '0;
      cnt_r    <= '0;
      dcount_r <= '0;
      run_r    <= 1'b0;
    end else begin
      ctl_r    <= ctl_nxt;
      cmp_r    <= cmp_nxt;
      cnt_r    <= cnt_nxt;
      dcount_r <= dcount_nxt;
      run_r    <= run_nxt;
    end
  end

  assign ctl_word = ctl_r;
  assign cmp_word = cmp_r;
  assign cnt_word = cnt_r;
  assign irq_nxt  = ctl_nxt[dct_pkg::TRIG_POS] & ctl_nxt[dct_pkg::IRQEN_POS];

endmodule

`default_nettype wire

/* hdl/dual_compare_timer.sv */
// Top level of the dual compare timer: input register, channels and result register.
`default_nettype none

// Usage: every item on the input channel (in_valid, in_stall, in_data) is a tick,
// a register read or a register write to one of the word registers; each item
// produces exactly one result item on the output channel (out_valid, out_stall,
// out_data) that carries the read data, both interrupt levels and the error flag.
// Interrupt levels and read data reflect the register state after the item.
// An accepted item waits in the input register, is processed on the way into the
// result register, and its result is offered from there. Throughput is one item
// per cycle while the receiver does not stall; the single decrement-and-compare
// step per channel sets that figure.
// When the receiver stalls, the result register holds its item and the input
// register fills; in_stall rises only when both are occupied, so one new item is
// still taken while a finished result waits. Register state only changes when an
// item moves into the result register, so stalls never skip or repeat ticks.
// Synchronous reset clears all channel registers, stops both down-counters and
// empties both pipeline registers; the block accepts items on the first cycle
// after reset is released. Accesses to indexes with no register read zero, change
// nothing and flag bad_access.
module dual_compare_timer #(
  parameter int NUM_CHANNELS = dct_pkg::NUM_CHANNELS_DEF,
  parameter int DATA_WIDTH   = dct_pkg::DATA_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  dct_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output dct_pkg::out_item_t  out_data
);

  localparam int WW = dct_pkg::WORD_WIDTH;

  // Input register stage.
  logic               s1_valid_r, s1_valid_nxt;
  dct_pkg::in_item_t  s1_item_r;
  // Result register stage.
  logic               out_valid_r, out_valid_nxt;
  dct_pkg::out_item_t out_item_r, out_item_nxt;

  logic               advance;
  logic               load_s1;
  logic               step;
  dct_pkg::reg_sel_t  sel;
  logic               is_access;
  logic               bad;

  logic [NUM_CHANNELS-1:0]  chan_irq;
  logic [DATA_WIDTH-1:0]    ctl_words [NUM_CHANNELS];
  logic [DATA_WIDTH-1:0]    cmp_words [NUM_CHANNELS];
  logic [DATA_WIDTH-1:0]    cnt_words [NUM_CHANNELS];
  dct_pkg::chan_cmd_t       chan_cmds [NUM_CHANNELS];
  logic [WW-1:0]            rd_data;
  logic                     irq_one_nxt;

  // The result register moves when it is empty or being taken; the input
  // register takes a new item whenever it is empty or passing its item on.
  assign advance  = !out_valid_r || !out_stall;
  assign load_s1  = !s1_valid_r || advance;
  assign in_stall = !load_s1;
  assign step     = s1_valid_r && advance;

  assign sel       = dct_pkg::decode_index(s1_item_r.reg_index);
  assign is_access = (s1_item_r.func == dct_pkg::FUNC_READ) ||
                     (s1_item_r.func == dct_pkg::FUNC_WRITE);
  assign bad       = is_access && (32'(sel.chan) >= NUM_CHANNELS);

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_cmds[c].tick   = step && (s1_item_r.func == dct_pkg::FUNC_TICK);
      chan_cmds[c].wr_ctl = step && (s1_item_r.func == dct_pkg::FUNC_WRITE) &&
                            (sel.chan == 3'(c)) && (sel.kind == dct_pkg::KIND_CTL);
      chan_cmds[c].wr_cmp = step && (s1_item_r.func == dct_pkg::FUNC_WRITE) &&
                            (sel.chan == 3'(c)) && (sel.kind == dct_pkg::KIND_CMP);
      chan_cmds[c].wr_cnt = step && (s1_item_r.func == dct_pkg::FUNC_WRITE) &&
                            (sel.chan == 3'(c)) && (sel.kind == dct_pkg::KIND_CNT);
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    dct_channel #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_chan (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (chan_cmds[g]),
      .wr_data  (s1_item_r.write_data[DATA_WIDTH-1:0]),
      .ctl_word (ctl_words[g]),
      .cmp_word (cmp_words[g]),
      .cnt_word (cnt_words[g]),
      .irq_nxt  (chan_irq[g])
    );
  end

  // Read mux: OR of the one selected word, zero for anything but a valid read.
  always_comb begin
    rd_data = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if ((s1_item_r.func == dct_pkg::FUNC_READ) && (sel.chan == 3'(c))) begin
        unique case (sel.kind)
          dct_pkg::KIND_CTL: rd_data = rd_data | WW'(ctl_words[c]);
          dct_pkg::KIND_CMP: rd_data = rd_data | WW'(cmp_words[c]);
          dct_pkg::KIND_CNT: rd_data = rd_data | WW'(cnt_words[c]);
          default:           rd_data = rd_data;
        endcase
      end
    end
  end

  if (NUM_CHANNELS > 1) begin : g_irq_one
    assign irq_one_nxt = chan_irq[1];
  end else begin : g_no_irq_one
    assign irq_one_nxt = 1'b0;
  end

  always_comb begin
    out_item_nxt.read_data  = rd_data;
    out_item_nxt.irq_zero   = chan_irq[0];
    out_item_nxt.irq_one    = irq_one_nxt;
    out_item_nxt.bad_access = bad;
  end

  assign s1_valid_nxt  = load_s1 ? in_valid : s1_valid_r;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1 && in_valid) begin
      s1_item_r <= in_data;
    end
    if (step) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // The input side only stalls when both pipeline registers are full and held.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall raised with a free pipeline register");

  // An accepted item always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted item lost before the input register");

  // An access to an unmapped index reads zero.
  a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_access) |-> (out_data.read_data == '0))
    else $error("bad access returned nonzero read data");

  // Read data never carries bits beyond the channel word width.
  a_rd_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.read_data >> DATA_WIDTH) == '0))
    else $error("read data wider than the channel words");

endmodule

`default_nettype wire

/* verif/dct_result_checker.sv */
// Result checker for the dual compare timer: predicts each result and compares it.
`timescale 1ns / 100ps

module dct_result_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_stall,
  input  dct_pkg::in_item_t  in_data,
  input  wire                out_valid,
  input  wire                out_stall,
  input  dct_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen,
  output int                 irq_results
);

  localparam int NCH        = dct_pkg::NUM_CHANNELS_DEF;
  localparam int WW         = dct_pkg::WORD_WIDTH;
  localparam int PRINT_MAX  = 30;

  // Shadow copy of the timer's registers and hidden counters.
  logic [WW-1:0] ctl_word  [NCH];
  logic [WW-1:0] cmp_word  [NCH];
  logic [WW-1:0] cnt_word  [NCH];
  logic [WW-1:0] remaining [NCH];
  logic          counting  [NCH];

  dct_pkg::out_item_t expected_results[$];

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= PRINT_MAX) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endtask

  // Applies one item to the shadow state and returns the result it gives.
  function automatic dct_pkg::out_item_t predict_timer_step(input dct_pkg::in_item_t it);
    dct_pkg::out_item_t res;
    int                 ch;
    int                 c;
    dct_pkg::kind_t     kind;
    res  = '0;
    ch   = int'(it.reg_index) / 3;
    kind = dct_pkg::kind_t'(it.reg_index % 3);
    case (it.func)
      dct_pkg::FUNC_TICK: begin
        for (c = 0; c < NCH; c++) begin
          if (counting[c]) begin
            if (remaining[c] > 1) begin
              remaining[c] = remaining[c] - 1'b1;
            end else begin
              ctl_word[c][dct_pkg::TRIG_POS] = 1'b1;
              if (ctl_word[c][dct_pkg::AR_POS]) begin
                remaining[c] = cmp_word[c];
              end else begin
                remaining[c] = '0;
                counting[c]  = 1'b0;
              end
            end
          end
        end
      end
      dct_pkg::FUNC_READ, dct_pkg::FUNC_WRITE: begin
        if (ch >= NCH) begin
          res.bad_access = 1'b1;
        end else if (it.func == dct_pkg::FUNC_READ) begin
          case (kind)
            dct_pkg::KIND_CTL: res.read_data = ctl_word[ch];
            dct_pkg::KIND_CMP: res.read_data = cmp_word[ch];
            default:           res.read_data = cnt_word[ch];
          endcase
        end else begin
          case (kind)
            dct_pkg::KIND_CTL: begin
              ctl_word[ch]                    = it.write_data;
              ctl_word[ch][dct_pkg::TRIG_POS] = 1'b0;
              counting[ch]                    = it.write_data[dct_pkg::EN_POS];
            end
            dct_pkg::KIND_CMP: begin
              cmp_word[ch]  = it.write_data;
              remaining[ch] = it.write_data;
            end
            default: cnt_word[ch] = it.write_data;
          endcase
        end
      end
      default: ;
    endcase
    res.irq_zero = ctl_word[0][dct_pkg::TRIG_POS] & ctl_word[0][dct_pkg::IRQEN_POS];
    res.irq_one  = ctl_word[1][dct_pkg::TRIG_POS] & ctl_word[1][dct_pkg::IRQEN_POS];
    return res;
  endfunction

  always @(posedge clk) begin
    dct_pkg::out_item_t want;
    int                 c;
    if (!rst_n) begin
      for (c = 0; c < NCH; c++) begin
        ctl_word[c]  = '0;
        cmp_word[c]  = '0;
        cnt_word[c]  = '0;
        remaining[c] = '0;
        counting[c]  = 1'b0;
      end
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_timer_step(in_data));
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.irq_zero === 1'b1 || out_data.irq_one === 1'b1) irq_results++;
        if (expected_results.size() == 0) begin
          report($sformatf("result %0h arrived with no item outstanding", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data)
            report($sformatf("read_data %h, expected %h", out_data.read_data, want.read_data));
          if (out_data.irq_zero !== want.irq_zero)
            report($sformatf("irq_zero %b, expected %b", out_data.irq_zero, want.irq_zero));
          if (out_data.irq_one !== want.irq_one)
            report($sformatf("irq_one %b, expected %b", out_data.irq_one, want.irq_one));
          if (out_data.bad_access !== want.bad_access)
            report($sformatf("bad_access %b, expected %b", out_data.bad_access,
                             want.bad_access));
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* verif/dual_compare_timer_tb.sv */
// Testbench top for the dual compare timer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module dual_compare_timer_tb;

  localparam int IW = dct_pkg::INDEX_WIDTH;
  localparam int WW = dct_pkg::WORD_WIDTH;

  // Word register map as seen on the bus; indexes six and seven have no register.
  localparam logic [IW-1:0] REG_CTL0  = 3'd0;
  localparam logic [IW-1:0] REG_CMP0  = 3'd1;
  localparam logic [IW-1:0] REG_CNT0  = 3'd2;
  localparam logic [IW-1:0] REG_CTL1  = 3'd3;
  localparam logic [IW-1:0] REG_CMP1  = 3'd4;
  localparam logic [IW-1:0] REG_CNT1  = 3'd5;
  localparam logic [IW-1:0] REG_HOLE6 = 3'd6;
  localparam logic [IW-1:0] REG_HOLE7 = 3'd7;

  // The fourth function code is not defined; the block must treat it as a no-op.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Control word bits.
  localparam logic [WW-1:0] CTL_TRIG  = 32'd1 << dct_pkg::TRIG_POS;
  localparam logic [WW-1:0] CTL_IRQEN = 32'd1 << dct_pkg::IRQEN_POS;
  localparam logic [WW-1:0] CTL_AR    = 32'd1 << dct_pkg::AR_POS;
  localparam logic [WW-1:0] CTL_EN    = 32'd1 << dct_pkg::EN_POS;

  localparam int RESET_CYCLES   = 9;
  localparam int ITEMS_PER_PASS = 510;
  localparam int LONG_HOLD      = 400;
  localparam int LATENCY        = 2;
  // The longest correct stretch without any handshake is the long receiver hold
  // (the block fills after two items); random stalls add little on top of that.
  localparam int STALL_LIMIT    = 4000;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  dct_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dct_pkg::out_item_t out_data;

  int        mismatches;
  int        pending;
  int        results_seen;
  int        irq_results;

  // Idle rates in percent for the sender and the receiver; changed per pass.
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      hold_req      = 1'b0;

  int        n_tick  = 0;
  int        n_read  = 0;
  int        n_write = 0;
  int        n_spare = 0;

  dual_compare_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  dct_result_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .irq_results  (irq_results)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Receiver: stalls at random at the current rate. When a long hold is asked
  // for, it keeps out_stall high through a long hold so that the result
  // register and the input register both fill and the block stalls its input.
  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 1; held < LONG_HOLD; held++) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no item moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet, pending);
        $display("dual_compare_timer test failed");
        $finish;
      end
    end
  end

  // Offers one item, possibly after some idle cycles, and returns in the time
  // step of the edge at which the block took it. in_valid stays high after
  // acceptance so that back-to-back items need no second assignment.
  task automatic send_item(input dct_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    case (it.func)
      dct_pkg::FUNC_TICK:  n_tick++;
      dct_pkg::FUNC_READ:  n_read++;
      dct_pkg::FUNC_WRITE: n_write++;
      default:             n_spare++;
    endcase
  endtask

  task automatic access(input logic [1:0] fn, input logic [IW-1:0] idx,
                        input logic [WW-1:0] data);
    dct_pkg::in_item_t it;
    it.func       = dct_pkg::func_t'(fn);
    it.reg_index  = idx;
    it.write_data = data;
    send_item(it);
  endtask

  // Stops offering items until every outstanding result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random item. Most items are ticks, and most writes are well-formed channel
  // setups (enable mostly set, small compare values) so that channels actually
  // hit, reload and stop; the rest are unmapped accesses, the spare code and
  // wide random data. Fields that an item ignores still carry random bits.
  function automatic dct_pkg::in_item_t random_item();
    dct_pkg::in_item_t it;
    int                pick;
    logic [WW-1:0]     data;
    it.write_data = $urandom;
    it.reg_index  = 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 52) begin
      it.func = dct_pkg::FUNC_TICK;
    end else if (pick < 96) begin
      it.func      = (pick < 66) ? dct_pkg::FUNC_READ : dct_pkg::FUNC_WRITE;
      it.reg_index = ($urandom_range(15) == 0) ? 3'($urandom_range(7))
                                               : 3'($urandom_range(5));
      if (it.func == dct_pkg::FUNC_WRITE && it.reg_index <= REG_CNT1) begin
        case (it.reg_index % 3)
          dct_pkg::KIND_CTL: begin
            data = ($urandom_range(3) == 0) ? $urandom : 32'd0;
            data = data & ~(CTL_TRIG | CTL_IRQEN | CTL_AR | CTL_EN);
            if ($urandom_range(4) != 0) data = data | CTL_EN;
            if ($urandom_range(1) != 0) data = data | CTL_AR;
            if ($urandom_range(9) < 7) data = data | CTL_IRQEN;
            if ($urandom_range(1) != 0) data = data | CTL_TRIG;
            it.write_data = data;
          end
          dct_pkg::KIND_CMP: begin
            case ($urandom_range(9))
              0:       it.write_data = $urandom;
              1:       it.write_data = 32'hFFFF_FFFF;
              default: it.write_data = $urandom_range(12);
            endcase
          end
          default: ;
        endcase
      end
    end else begin
      it.func = dct_pkg::func_t'(FUNC_SPARE);
    end
    return it;
  endfunction

  initial begin
    int pass;
    int i;
    int idx;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Reset values of every index, including the two holes.
    for (idx = 0; idx < 8; idx++) access(dct_pkg::FUNC_READ, idx[IW-1:0], $urandom);
    // Channel 1 one-shot from compare 2: one plain tick, then it hits and stops
    // with the down-count left at zero.
    access(dct_pkg::FUNC_WRITE, REG_CMP1, 32'd2);
    access(dct_pkg::FUNC_WRITE, REG_CTL1, CTL_EN | CTL_IRQEN);
    // All ones to channel 0 control: the trigger bit must not stick, and with
    // auto-reload from compare zero the channel hits on every tick.
    access(dct_pkg::FUNC_WRITE, REG_CTL0, 32'hFFFF_FFFF);
    repeat (3) access(dct_pkg::FUNC_TICK, REG_HOLE7, 32'hFFFF_FFFF);
    access(dct_pkg::FUNC_READ, REG_CTL1, 32'd0);
    access(dct_pkg::FUNC_WRITE, REG_CNT0, 32'hFFFF_FFFF);
    access(dct_pkg::FUNC_READ, REG_CNT0, 32'd0);
    // Unmapped write and read, then the undefined function code.
    access(dct_pkg::FUNC_WRITE, REG_HOLE6, 32'hFFFF_FFFF);
    access(dct_pkg::FUNC_READ, REG_HOLE7, 32'hFFFF_FFFF);
    access(FUNC_SPARE, REG_HOLE7, 32'hFFFF_FFFF);
    // Clearing the control word drops the trigger and the interrupt.
    access(dct_pkg::FUNC_WRITE, REG_CTL0, 32'd0);
    access(dct_pkg::FUNC_WRITE, REG_CMP0, 32'hFFFF_FFFF);
    access(dct_pkg::FUNC_WRITE, REG_CTL0, CTL_EN | CTL_AR);
    access(dct_pkg::FUNC_TICK, REG_CTL0, 32'd0);
    // Restarting channel 1 with a down-count already at zero hits at once and
    // reloads from its own compare value.
    access(dct_pkg::FUNC_WRITE, REG_CTL1, CTL_EN | CTL_AR | CTL_IRQEN);
    access(dct_pkg::FUNC_TICK, REG_CTL0, 32'd0);
    access(dct_pkg::FUNC_READ, REG_CMP0, 32'd0);
    drain_results();

    // Random part in three passes: slow receiver, slow sender, then full rate.
    // The last pass also carries the long receiver hold.
    for (pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin send_idle_pct = 9;  recv_idle_pct = 87; end
        1: begin send_idle_pct = 87; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (i = 0; i < ITEMS_PER_PASS; i++) begin
        if (i == ITEMS_PER_PASS / 2) drain_results();
        if (pass == 2 && i == ITEMS_PER_PASS / 4) hold_req <= 1'b1;
        send_item(random_item());
      end
      drain_results();
    end

    // Anything arriving now would be a result nobody asked for.
    repeat (4 * LATENCY) @(posedge clk);

    $display("Sent %0d ticks, %0d reads, %0d writes and %0d undefined-code items",
             n_tick, n_read, n_write, n_spare);
    $display("over three idle profiles; %0d results checked, %0d with an interrupt high.",
             results_seen, irq_results);
    if (mismatches == 0 && pending == 0) begin
      $display("dual_compare_timer test passed");
    end else begin
      $display("dual_compare_timer test failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/dct_pkg.sv
hdl/dct_channel.sv
hdl/dual_compare_timer.sv
verif/dct_result_checker.sv
verif/dual_compare_timer_tb.sv
